@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of the running median tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is high.
`define RMT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RMT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/rmt_pkg.sv @@
// Types and constants shared by the running median tracker modules.
`default_nettype none

package rmt_pkg;

   localparam int DATA_W     = 32;
   localparam int GROUP_SIZE = 16;

   // What one cell hands to its right-hand neighbor.
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              le;
      logic              marker;
   } link_type;

   // Controls broadcast from the top level to every cell.
   typedef struct packed {
      logic insert;
      logic step_marker;
      logic home_marker;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/running_median_tracker.sv @@
// Running median tracker: sorted chain of cells with a moving median marker.
// Throughput: one request per clock cycle; busy stays low, start is never refused.
// An accepted request updates the chain cells; its result then passes the OR tree's
// group register and the output registers before it strobes.
// Reset (synchronous, active high) empties the store and drops requests in flight;
// the receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none

module running_median_tracker #(
   parameter int CAPACITY = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_start_sequence,
   input  wire logic signed [31:0] req_sample,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_median,
   output logic                    rsp_overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // The store is a row of cells ordered from the smallest value at cell 0.
   // A new sample is broadcast to every cell; each cell either keeps its value,
   // takes the sample, or takes its left neighbor's value, so the whole row
   // shifts right by one behind the insertion point, all cells in the same update.
   // A one-hot marker sits on the cell at index (count - 1) / 2 and moves right
   // by one cell whenever an insertion makes the count odd.

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_eff;
   logic             accept;
   logic             full;
   logic             insert;

   logic             emit0_ff, emit0_in;
   logic             ovf0_ff, ovf0_in;
   logic             emit1_ff;
   logic             ovf1_ff;
   logic             rsp_strobe_ff;
   logic             rsp_overflow_ff;
   logic [31:0]      rsp_median_ff, rsp_median_in;

   rmt_pkg::cell_ctrl_type                       ctrl;
   rmt_pkg::link_type [CAPACITY:0]               links;
   logic [CAPACITY-1:0][rmt_pkg::DATA_W-1:0]     taps;
   logic [CAPACITY-1:0]                          occupied;
   logic [CAPACITY-1:0]                          markers;
   logic [rmt_pkg::DATA_W-1:0]                   tree_out;

   // Every request is taken as it comes.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // A start of sequence empties the store before its own sample goes in.
   assign count_eff = req_start_sequence ? '0 : count_ff;
   assign full      = (count_eff == CNT_W'(CAPACITY));
   assign insert    = accept && !full;

   assign ctrl.insert      = insert;
   // The marker moves only when the count becomes odd, that is, when it was
   // even before this insertion; from an empty store it lands on cell 0.
   assign ctrl.step_marker = insert && !count_eff[0];
   assign ctrl.home_marker = (count_eff == '0);

   always_comb begin
      count_in = count_ff;
      if (insert) begin
         count_in = count_eff + CNT_W'(1);
      end else if (accept) begin
         count_in = count_eff;
      end
   end

   // A result follows every overflow and every insertion that leaves an odd count.
   assign emit0_in = accept && (full || !count_eff[0]);
   assign ovf0_in  = accept && full;

   assign links[0] = '{value: '0, le: 1'b1, marker: 1'b0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = (count_eff > CNT_W'(i));

      rmt_cell #(
         .IS_FIRST (i == 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .occupied (occupied[i]),
         .sample   (req_sample),
         .left     (links[i]),
         .right    (links[i+1]),
         .tap      (taps[i])
      );

      assign markers[i] = links[i+1].marker;
   end

   // Only the marked cell drives a nonzero tap, so an OR over all taps
   // yields the median.
   rmt_or_tree #(
      .N (CAPACITY)
   ) u_tree (
      .clock  (clock),
      .taps   (taps),
      .result (tree_out)
   );

   // An overflow result carries a median of zero.
   assign rsp_median_in = ovf1_ff ? '0 : tree_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         emit0_ff        <= 1'b0;
         ovf0_ff         <= 1'b0;
         emit1_ff        <= 1'b0;
         ovf1_ff         <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         rsp_overflow_ff <= 1'b0;
      end else begin
         count_ff        <= count_in;
         emit0_ff        <= emit0_in;
         ovf0_ff         <= ovf0_in;
         emit1_ff        <= emit0_ff;
         ovf1_ff         <= ovf0_ff;
         rsp_strobe_ff   <= emit1_ff;
         rsp_overflow_ff <= ovf1_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_median   = rsp_median_ff;

`include "assert_macros.svh"

   // The fill count never runs past the number of cells.
   `RMT_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "store count exceeds capacity")

   // Exactly one cell carries the median marker while the store is not empty.
   `RMT_ASSERT(a_marker_onehot, (count_ff != '0) |-> $onehot(markers), "median marker not one-hot")

   // A request that meets a full store comes back as an overflow result on time.
   `RMT_ASSERT(a_ovf_latency, (accept && full) |=> ##2 (rsp_strobe && rsp_overflow), "overflow result missing")

endmodule

`default_nettype wire

@@ rtl/core/rmt_cell.sv @@
// One slot of the sorted chain: a stored value and the median marker bit.
`default_nettype none

module rmt_cell #(
   parameter bit IS_FIRST = 1'b0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rmt_pkg::cell_ctrl_type      ctrl,
   input  wire logic                        occupied,
   input  wire logic [rmt_pkg::DATA_W-1:0]  sample,
   input  wire rmt_pkg::link_type           left,
   output rmt_pkg::link_type                right,
   output logic [rmt_pkg::DATA_W-1:0]       tap
);

   logic [rmt_pkg::DATA_W-1:0] value_ff, value_in;
   logic                       marker_ff, marker_in;
   logic                       le;

   // Stored values form an ascending prefix, so the cells that hold a value
   // not above the sample form a prefix too.
   assign le = occupied && ($signed(value_ff) <= $signed(sample));

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && !le) begin
         value_in = left.le ? sample : left.value;
      end
      marker_in = marker_ff;
      if (ctrl.step_marker) begin
         marker_in = ctrl.home_marker ? IS_FIRST : left.marker;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= 1'b0;
      end else begin
         marker_ff <= marker_in;
      end
   end

   assign right = '{value: value_ff, le: le, marker: marker_ff};
   assign tap   = marker_ff ? value_ff : '0;

endmodule

`default_nettype wire

@@ rtl/core/rmt_or_tree.sv @@
// Two-level OR reduction of the cell taps, registered after the first level.
`default_nettype none

module rmt_or_tree #(
   parameter int N = 256
) (
   input  wire logic                                clock,
   input  wire logic [N-1:0][rmt_pkg::DATA_W-1:0]   taps,
   output logic [rmt_pkg::DATA_W-1:0]               result
);

   localparam int NGRP = (N + rmt_pkg::GROUP_SIZE - 1) / rmt_pkg::GROUP_SIZE;
   localparam int NPAD = NGRP * rmt_pkg::GROUP_SIZE;

   logic [NPAD-1:0][rmt_pkg::DATA_W-1:0] padded;
   logic [NGRP-1:0][rmt_pkg::DATA_W-1:0] group_ff, group_in;

   always_comb begin
      padded        = '0;
      padded[N-1:0] = taps;
   end

   always_comb begin
      group_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         for (int j = 0; j < rmt_pkg::GROUP_SIZE; j++) begin
            group_in[g] = group_in[g] | padded[g*rmt_pkg::GROUP_SIZE + j];
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   always_comb begin
      result = '0;
      for (int g = 0; g < NGRP; g++) begin
         result = result | group_ff[g];
      end
   end

endmodule

`default_nettype wire
